// ===== hdl/imabd_pkg.sv =====
// Shared types, constants and tables for the IMA ADPCM byte decoder.
// Holds the item structs, the step-size table and the index-adjust table.
// No dependencies.
package imabd_pkg;

    localparam logic [6:0]         MAX_STEP_POS = 7'd88;
    localparam logic signed [17:0] PCM_MAX      = 18'sd32767;
    localparam logic signed [17:0] PCM_MIN      = -18'sd32768;

    typedef struct packed {
        logic               start_packet;
        logic signed [15:0] seed_sample;
        logic [7:0]         seed_index;
        logic [7:0]         code_byte;
        logic               final_byte;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] pcm_sample;
        logic               second_of_pair;
        logic               packet_end;
    } t_out_item;

    // Index adjustment from the three magnitude bits of a code.
    function automatic logic signed [4:0] imabd_index_adj(input logic [2:0] mag);
        logic signed [4:0] adj;
        case (mag)
            3'd4:    adj = 5'sd2;
            3'd5:    adj = 5'sd4;
            3'd6:    adj = 5'sd6;
            3'd7:    adj = 5'sd8;
            default: adj = -5'sd1;
        endcase
        return adj;
    endfunction

    // Step size for a step position of 0..88.
    function automatic logic [14:0] imabd_step(input logic [6:0] pos);
        logic [14:0] s;
        case (pos)
            7'd0:  s = 15'd7;     7'd1:  s = 15'd8;     7'd2:  s = 15'd9;
            7'd3:  s = 15'd10;    7'd4:  s = 15'd11;    7'd5:  s = 15'd12;
            7'd6:  s = 15'd13;    7'd7:  s = 15'd14;    7'd8:  s = 15'd16;
            7'd9:  s = 15'd17;    7'd10: s = 15'd19;    7'd11: s = 15'd21;
            7'd12: s = 15'd23;    7'd13: s = 15'd25;    7'd14: s = 15'd28;
            7'd15: s = 15'd31;    7'd16: s = 15'd34;    7'd17: s = 15'd37;
            7'd18: s = 15'd41;    7'd19: s = 15'd45;    7'd20: s = 15'd50;
            7'd21: s = 15'd55;    7'd22: s = 15'd60;    7'd23: s = 15'd66;
            7'd24: s = 15'd73;    7'd25: s = 15'd80;    7'd26: s = 15'd88;
            7'd27: s = 15'd97;    7'd28: s = 15'd107;   7'd29: s = 15'd118;
            7'd30: s = 15'd130;   7'd31: s = 15'd143;   7'd32: s = 15'd157;
            7'd33: s = 15'd173;   7'd34: s = 15'd190;   7'd35: s = 15'd209;
            7'd36: s = 15'd230;   7'd37: s = 15'd253;   7'd38: s = 15'd279;
            7'd39: s = 15'd307;   7'd40: s = 15'd337;   7'd41: s = 15'd371;
            7'd42: s = 15'd408;   7'd43: s = 15'd449;   7'd44: s = 15'd494;
            7'd45: s = 15'd544;   7'd46: s = 15'd598;   7'd47: s = 15'd658;
            7'd48: s = 15'd724;   7'd49: s = 15'd796;   7'd50: s = 15'd876;
            7'd51: s = 15'd963;   7'd52: s = 15'd1060;  7'd53: s = 15'd1166;
            7'd54: s = 15'd1282;  7'd55: s = 15'd1411;  7'd56: s = 15'd1552;
            7'd57: s = 15'd1707;  7'd58: s = 15'd1878;  7'd59: s = 15'd2066;
            7'd60: s = 15'd2272;  7'd61: s = 15'd2499;  7'd62: s = 15'd2749;
            7'd63: s = 15'd3024;  7'd64: s = 15'd3327;  7'd65: s = 15'd3660;
            7'd66: s = 15'd4026;  7'd67: s = 15'd4428;  7'd68: s = 15'd4871;
            7'd69: s = 15'd5358;  7'd70: s = 15'd5894;  7'd71: s = 15'd6484;
            7'd72: s = 15'd7132;  7'd73: s = 15'd7845;  7'd74: s = 15'd8630;
            7'd75: s = 15'd9493;  7'd76: s = 15'd10442; 7'd77: s = 15'd11487;
            7'd78: s = 15'd12635; 7'd79: s = 15'd13899; 7'd80: s = 15'd15289;
            7'd81: s = 15'd16818; 7'd82: s = 15'd18500; 7'd83: s = 15'd20350;
            7'd84: s = 15'd22385; 7'd85: s = 15'd24623; 7'd86: s = 15'd27086;
            7'd87: s = 15'd29794;
            default: s = 15'd32767;
        endcase
        return s;
    endfunction

endpackage

// ===== hdl/imabd_nibble.sv =====
// Combinational decode of one 4-bit IMA ADPCM code.
// Depends on imabd_pkg for the step and index tables.
module imabd_nibble (
    input  logic signed [15:0] i_sample,
    input  logic [6:0]         i_pos,
    input  logic [3:0]         i_code,
    output logic signed [15:0] o_sample,
    output logic [6:0]         o_pos
);
    import imabd_pkg::*;

    logic [14:0]        step;
    logic [16:0]        diff;
    logic signed [17:0] diff_s;
    logic signed [17:0] sum;
    logic signed [4:0]  adj;
    logic signed [8:0]  pos_sum;

    always_comb begin
        step   = imabd_step(i_pos);
        diff   = {2'b00, step >> 3}
               + (i_code[2] ? {2'b00, step}      : 17'd0)
               + (i_code[1] ? {2'b00, step >> 1} : 17'd0)
               + (i_code[0] ? {2'b00, step >> 2} : 17'd0);
        diff_s = signed'({1'b0, diff});
        sum    = {{2{i_sample[15]}}, i_sample} + (i_code[3] ? -diff_s : diff_s);

        if (sum > PCM_MAX) begin
            o_sample = PCM_MAX[15:0];
        end else if (sum < PCM_MIN) begin
            o_sample = PCM_MIN[15:0];
        end else begin
            o_sample = sum[15:0];
        end

        adj     = imabd_index_adj(i_code[2:0]);
        pos_sum = signed'({2'b00, i_pos}) + {{4{adj[4]}}, adj};
        if (pos_sum < 9'sd0) begin
            o_pos = 7'd0;
        end else if (pos_sum > signed'({2'b00, MAX_STEP_POS})) begin
            o_pos = MAX_STEP_POS;
        end else begin
            o_pos = pos_sum[6:0];
        end
    end

endmodule

// ===== hdl/ima_adpcm_byte_decoder_unit.sv =====
// IMA ADPCM byte decoder: each item carries one code byte and yields two PCM samples.
// The item is held in the input register; each sample is then registered in the result register, high nibble first.
// Throughput: one sample per cycle while the output does not stall, set by the single nibble decoder
// and the output channel, which carries one sample per cycle; a new item is taken as the last nibble moves.
// Reset (synchronous, active low) clears predictor sample, step position and valid flags.
// Depends on imabd_pkg and imabd_nibble.
module ima_adpcm_byte_decoder_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  imabd_pkg::t_in_item  i_in_data,
    output logic                 o_in_stall,
    output logic                 o_out_valid,
    output imabd_pkg::t_out_item o_out_data,
    input  logic                 i_out_stall
);
    import imabd_pkg::*;

    // Input holding register: one code byte, plus which nibble is next.
    t_in_item           r_in;
    logic               r_in_valid, n_in_valid;
    logic               r_phase, n_phase;

    // Decoder state carried from sample to sample.
    logic signed [15:0] r_sample, n_sample;
    logic [6:0]         r_pos, n_pos;

    // Result register toward the output channel.
    t_out_item          r_out, n_out;
    logic               r_out_valid, n_out_valid;

    logic               in_take;
    logic               adv;
    logic               seed_now;
    logic signed [15:0] cur_sample;
    logic [6:0]         cur_pos;
    logic [3:0]         cur_code;
    logic signed [15:0] dec_sample;
    logic [6:0]         dec_pos;

    // Decode a nibble whenever one is pending and the result register is free
    // or being drained this cycle.
    assign adv = r_in_valid && (!r_out_valid || !i_out_stall);

    // Take a new byte when none is held, or as soon as the held one is on its last nibble and moving.
    assign o_in_stall = r_in_valid && !(adv && r_phase);
    assign in_take    = i_in_valid && !o_in_stall;

    // Seed the predictor only ahead of the high nibble of a start byte.
    always_comb begin
        seed_now   = !r_phase && r_in.start_packet;
        cur_sample = seed_now ? r_in.seed_sample : r_sample;
        if (!seed_now) begin
            cur_pos = r_pos;
        end else if (r_in.seed_index > {1'b0, MAX_STEP_POS}) begin
            cur_pos = MAX_STEP_POS;
        end else begin
            cur_pos = r_in.seed_index[6:0];
        end
        // High nibble first, then low nibble.
        cur_code = r_phase ? r_in.code_byte[3:0] : r_in.code_byte[7:4];
    end

    imabd_nibble u_nibble (
        .i_sample (cur_sample),
        .i_pos    (cur_pos),
        .i_code   (cur_code),
        .o_sample (dec_sample),
        .o_pos    (dec_pos)
    );

    always_comb begin
        n_in_valid  = r_in_valid;
        n_phase     = r_phase;
        n_sample    = r_sample;
        n_pos       = r_pos;
        n_out       = r_out;
        n_out_valid = r_out_valid;

        // Drop the shown result once taken.
        if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end

        if (adv) begin
            n_sample                = dec_sample;
            n_pos                   = dec_pos;
            n_out.pcm_sample        = dec_sample;
            n_out.second_of_pair    = r_phase;
            n_out.packet_end        = r_phase && r_in.final_byte;
            n_out_valid             = 1'b1;
            n_phase                 = !r_phase;
            if (r_phase) begin
                n_in_valid = 1'b0;
            end
        end

        // A new byte starts on its high nibble.
        if (in_take) begin
            n_in_valid = 1'b1;
            n_phase    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_phase     <= 1'b0;
            r_sample    <= '0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_phase     <= n_phase;
            r_sample    <= n_sample;
            r_pos       <= n_pos;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers: no reset.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in_data;
        end
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTH
    // The low-nibble phase only exists while a byte is held.
    a_phase_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase |-> r_in_valid)
        else $error("low-nibble phase without a held item");

    // Step position stays inside the table.
    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= MAX_STEP_POS)
        else $error("step position beyond table");

    // A taken byte is held next cycle, starting on its high nibble.
    a_take_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |=> (r_in_valid && !r_phase))
        else $error("accepted item not held on high nibble");

    // Packet end only flags the second sample of a pair.
    a_end_on_second: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.packet_end) |-> o_out_data.second_of_pair)
        else $error("packet end on first sample");

    // A high-nibble result is always followed by its low-nibble partner.
    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && !r_phase) |=> (r_in_valid && r_phase))
        else $error("high nibble not followed by low nibble");
`endif

endmodule
